FILE: hdl/scba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scba_pkg
// shared widths, codes and the classified request word for the allocator
// ----------------------------------------------------------------------------
package scba_pkg;

  localparam int START_W  = 10;
  localparam int SIZE_W   = 5;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 11;

  localparam logic [CFG_W-1:0] BOOT_RESET = 11'd1;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_t;

  typedef struct packed {
    logic              is_free;
    logic              size_ok;
    logic              start_ok;
    logic [SIZE_W-1:0] size;
    logic [START_W-1:0] start;
  } item_t;

endpackage

FILE: hdl/scba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scba_ram
// simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module scba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/scba_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scba_front
// request intake: decodes the command and range-checks size and start
// ----------------------------------------------------------------------------
module scba_front #(
  parameter int TABLE_DEPTH = 1024,
  parameter int MAX_BLOCK   = 16
) (
  input  logic                         push,
  output logic                         full,
  input  logic                         in_cmd,
  input  logic [scba_pkg::SIZE_W-1:0]  in_block_size,
  input  logic [scba_pkg::START_W-1:0] in_block_start,
  input  logic                         q_full,
  input  logic                         busy,
  output logic                         q_push,
  output scba_pkg::item_t              q_item
);

  localparam int SZ_W    = $clog2(MAX_BLOCK + 1);
  localparam int SCMP_W  = (SZ_W > scba_pkg::SIZE_W) ? SZ_W : scba_pkg::SIZE_W;
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int ICMP_W  = (CNT_W > scba_pkg::START_W) ? CNT_W : scba_pkg::START_W;

  logic size_ok;
  logic start_ok;

  assign size_ok  = (in_block_size != '0) &&
                    (SCMP_W'(in_block_size) <= SCMP_W'(MAX_BLOCK));
  // index zero is never a freeable block
  assign start_ok = (in_block_start != '0) &&
                    (ICMP_W'(in_block_start) < ICMP_W'(TABLE_DEPTH));

  assign full   = q_full || busy;
  assign q_push = push && !full;

  always_comb begin
    q_item.is_free  = (in_cmd == scba_pkg::CMD_FREE);
    q_item.size_ok  = size_ok;
    q_item.start_ok = start_ok;
    q_item.size     = in_block_size;
    q_item.start    = in_block_start;
  end

endmodule

FILE: hdl/scba_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scba_queue
// short fifo of classified requests between intake and execution
// ----------------------------------------------------------------------------
module scba_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            flush,
  input  logic            push,
  input  scba_pkg::item_t item_in,
  output logic            full,
  input  logic            pop,
  output scba_pkg::item_t item_out,
  output logic            valid
);

  localparam int QD    = scba_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(QD);
  localparam int CNT_W = $clog2(QD + 1);

  scba_pkg::item_t  mem_r [QD];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full     = (count_r == CNT_W'(QD));
  assign valid    = (count_r != '0);
  assign item_out = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QD - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QD - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
    if (flush) begin
      wr_ptr_nxt = '0;
      rd_ptr_nxt = '0;
      count_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

FILE: hdl/scba_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scba_back
// execution sequencer: list heads, links and block marks, result register
// ----------------------------------------------------------------------------
module scba_back #(
  parameter int TABLE_DEPTH = 1024,
  parameter int MAX_BLOCK   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [scba_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          q_valid,
  input  scba_pkg::item_t               q_item,
  output logic                          q_pop,
  output logic                          busy,
  output logic                          empty,
  input  logic                          pop,
  output logic [scba_pkg::START_W-1:0]  out_start_index,
  output logic [scba_pkg::STATUS_W-1:0] out_status,
  output logic                          out_from_free_list,
  output logic [scba_pkg::SIZE_W-1:0]   out_freed_size
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int LST_W  = $clog2(MAX_BLOCK);
  localparam int SZ_W   = $clog2(MAX_BLOCK + 1);
  localparam int WIDE_W = (CNT_W > scba_pkg::CFG_W) ? CNT_W : scba_pkg::CFG_W;
  localparam int SCMP_W = (CNT_W > scba_pkg::SIZE_W) ? CNT_W : scba_pkg::SIZE_W;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RD1,
    S_RD2
  } state_t;

  state_t                       state_r, state_nxt;
  logic [IDX_W-1:0]             clr_cnt_r, clr_cnt_nxt;
  scba_pkg::item_t              op_r, op_nxt;
  logic [IDX_W-1:0]             idx_r, idx_nxt;
  logic [SZ_W-1:0]              sz_r, sz_nxt;
  logic [MAX_BLOCK-1:0]         head_valid_r, head_valid_nxt;
  logic [CNT_W-1:0]             seed_lim_r, seed_lim_nxt;
  logic [CNT_W-1:0]             seed_next_r, seed_next_nxt;
  logic [CNT_W-1:0]             high_water_r, high_water_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [scba_pkg::START_W-1:0] out_start_r, out_start_nxt;
  scba_pkg::status_t            out_status_r, out_status_nxt;
  logic                         out_reused_r, out_reused_nxt;
  logic [scba_pkg::SIZE_W-1:0]  out_freed_r, out_freed_nxt;

  logic                 head_we;
  logic [LST_W-1:0]     head_waddr, head_raddr;
  logic [IDX_W-1:0]     head_wdata, head_rdata;
  logic                 link_we;
  logic [IDX_W-1:0]     link_waddr, link_raddr;
  logic [IDX_W:0]       link_wdata, link_rdata;
  logic                 meta_we;
  logic [IDX_W-1:0]     meta_waddr, meta_raddr;
  logic [SZ_W:0]        meta_wdata, meta_rdata;

  logic [LST_W-1:0]     op_lst;
  logic [LST_W-1:0]     sz_lst;
  logic [CNT_W-1:0]     room;
  logic                 bump_fits;
  logic [WIDE_W-1:0]    boot_wide;
  logic [WIDE_W-1:0]    boot_clamp;

  assign op_lst    = LST_W'(op_r.size - scba_pkg::SIZE_W'(1));
  assign sz_lst    = LST_W'(sz_r - SZ_W'(1));
  assign room      = CNT_W'(TABLE_DEPTH) - high_water_r;
  assign bump_fits = SCMP_W'(op_r.size) <= SCMP_W'(room);
  assign boot_wide = WIDE_W'(cfg_wdata);
  assign boot_clamp = (boot_wide > WIDE_W'(TABLE_DEPTH)) ? WIDE_W'(TABLE_DEPTH) : boot_wide;

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    op_nxt         = op_r;
    idx_nxt        = idx_r;
    sz_nxt         = sz_r;
    head_valid_nxt = head_valid_r;
    seed_lim_nxt   = seed_lim_r;
    seed_next_nxt  = seed_next_r;
    high_water_nxt = high_water_r;
    out_valid_nxt  = out_valid_r;
    out_start_nxt  = out_start_r;
    out_status_nxt = out_status_r;
    out_reused_nxt = out_reused_r;
    out_freed_nxt  = out_freed_r;

    q_pop      = 1'b0;
    head_we    = 1'b0;
    head_waddr = op_lst;
    head_wdata = link_rdata[IDX_W-1:0];
    head_raddr = LST_W'(q_item.size - scba_pkg::SIZE_W'(1));
    link_we    = 1'b0;
    link_waddr = IDX_W'(op_r.start);
    link_wdata = {head_valid_r[sz_lst], head_rdata};
    link_raddr = head_rdata;
    meta_we    = 1'b0;
    meta_waddr = idx_r;
    meta_wdata = {1'b1, SZ_W'(op_r.size)};
    meta_raddr = IDX_W'(q_item.start);

    if (pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_cnt_r;
        meta_wdata = '0;
        if (clr_cnt_r == IDX_W'(TABLE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + IDX_W'(1);
        end
      end
      S_IDLE: begin
        // start only with the result register free so the finish never stalls
        if (q_valid && !out_valid_r) begin
          q_pop     = 1'b1;
          op_nxt    = q_item;
          state_nxt = S_RD1;
        end
      end
      S_RD1: begin
        out_start_nxt  = '0;
        out_status_nxt = scba_pkg::ST_OK;
        out_reused_nxt = 1'b0;
        out_freed_nxt  = '0;
        if (!op_r.is_free) begin
          if (!op_r.size_ok) begin
            out_status_nxt = scba_pkg::ST_NO_SPACE;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_IDLE;
          end else if (head_valid_r[op_lst]) begin
            // head index is on the read port, fetch its link next
            idx_nxt   = head_rdata;
            state_nxt = S_RD2;
          end else if ((op_r.size == scba_pkg::SIZE_W'(1)) &&
                       (seed_next_r < seed_lim_r)) begin
            meta_we        = 1'b1;
            meta_waddr     = IDX_W'(seed_next_r);
            seed_next_nxt  = seed_next_r + CNT_W'(1);
            out_start_nxt  = scba_pkg::START_W'(seed_next_r);
            out_reused_nxt = 1'b1;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_IDLE;
          end else if (bump_fits) begin
            meta_we        = 1'b1;
            meta_waddr     = IDX_W'(high_water_r);
            high_water_nxt = high_water_r + CNT_W'(op_r.size);
            out_start_nxt  = scba_pkg::START_W'(high_water_r);
            out_valid_nxt  = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            out_status_nxt = scba_pkg::ST_NO_SPACE;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else begin
          out_start_nxt = op_r.start;
          if (!op_r.start_ok || !meta_rdata[SZ_W]) begin
            out_status_nxt = scba_pkg::ST_BAD_FREE;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            sz_nxt     = meta_rdata[SZ_W-1:0];
            head_raddr = LST_W'(meta_rdata[SZ_W-1:0] - SZ_W'(1));
            state_nxt  = S_RD2;
          end
        end
      end
      S_RD2: begin
        out_status_nxt = scba_pkg::ST_OK;
        out_valid_nxt  = 1'b1;
        state_nxt      = S_IDLE;
        if (!op_r.is_free) begin
          head_we                = 1'b1;
          head_valid_nxt[op_lst] = link_rdata[IDX_W];
          meta_we                = 1'b1;
          out_start_nxt          = scba_pkg::START_W'(idx_r);
          out_reused_nxt         = 1'b1;
          out_freed_nxt          = '0;
        end else begin
          // push the block on the list of its stored size
          link_we                = 1'b1;
          head_we                = 1'b1;
          head_waddr             = sz_lst;
          head_wdata             = IDX_W'(op_r.start);
          head_valid_nxt[sz_lst] = 1'b1;
          meta_we                = 1'b1;
          meta_waddr             = IDX_W'(op_r.start);
          meta_wdata             = {1'b0, sz_r};
          out_start_nxt          = op_r.start;
          out_reused_nxt         = 1'b0;
          out_freed_nxt          = scba_pkg::SIZE_W'(sz_r);
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase

    // register write restarts everything and sweeps the block marks
    if (cfg_we) begin
      state_nxt      = S_CLEAR;
      clr_cnt_nxt    = '0;
      head_valid_nxt = '0;
      seed_lim_nxt   = CNT_W'(boot_clamp);
      seed_next_nxt  = '0;
      high_water_nxt = CNT_W'(boot_clamp);
      out_valid_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      head_valid_r <= '0;
      seed_lim_r   <= CNT_W'(scba_pkg::BOOT_RESET);
      seed_next_r  <= '0;
      high_water_r <= CNT_W'(scba_pkg::BOOT_RESET);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      head_valid_r <= head_valid_nxt;
      seed_lim_r   <= seed_lim_nxt;
      seed_next_r  <= seed_next_nxt;
      high_water_r <= high_water_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    idx_r        <= idx_nxt;
    sz_r         <= sz_nxt;
    out_start_r  <= out_start_nxt;
    out_status_r <= out_status_nxt;
    out_reused_r <= out_reused_nxt;
    out_freed_r  <= out_freed_nxt;
  end

  scba_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_BLOCK)
  ) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .raddr (head_raddr),
    .rdata (head_rdata)
  );

  scba_ram #(
    .WIDTH (IDX_W + 1),
    .DEPTH (TABLE_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  // block mark: in-use flag over stored size
  scba_ram #(
    .WIDTH (SZ_W + 1),
    .DEPTH (TABLE_DEPTH)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  assign busy               = (state_r == S_CLEAR);
  assign empty              = !out_valid_r;
  assign out_start_index    = out_start_r;
  assign out_status         = out_status_r;
  assign out_from_free_list = out_reused_r;
  assign out_freed_size     = out_freed_r;

`ifndef SYNTHESIS
  a_seed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seed_next_r <= seed_lim_r)
    else $error("seed pointer passed the seed limit");

  a_bump_bound: assert property (@(posedge clk) disable iff (!rst_n)
    high_water_r <= CNT_W'(TABLE_DEPTH))
    else $error("bump pointer passed the table end");

  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (state_r == S_IDLE))
    else $error("result word posted without returning to idle");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_valid_r)
    else $error("result word pending during clearing sweep");

  a_rd2_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD2) |=> (state_r == S_IDLE || state_r == S_CLEAR))
    else $error("second read step did not finish the request");
`endif

endmodule

FILE: hdl/size_class_block_allocator_unit.sv
`timescale 1ns / 1ps
// a result word is posted from read step RD1, or from RD2 when it pops a free list
//   or frees a block (head then link, or mark then head)
// the queue takes new requests while one executes; the sequencer starts the next one
//   only from idle with the result word popped, after both dependent table reads
// reset and every boot_count write start a clearing sweep over all TABLE_DEPTH
//   block marks; full stays high until it ends
// ----------------------------------------------------------------------------
// size_class_block_allocator_unit
// size-class block allocator with per-size free lists and a bump pointer
// ----------------------------------------------------------------------------
module size_class_block_allocator_unit #(
  parameter int TABLE_DEPTH = 1024,
  parameter int MAX_BLOCK   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [scba_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          push,
  output logic                          full,
  input  logic                          in_cmd,
  input  logic [scba_pkg::SIZE_W-1:0]   in_block_size,
  input  logic [scba_pkg::START_W-1:0]  in_block_start,
  output logic                          empty,
  input  logic                          pop,
  output logic [scba_pkg::START_W-1:0]  out_start_index,
  output logic [scba_pkg::STATUS_W-1:0] out_status,
  output logic                          out_from_free_list,
  output logic [scba_pkg::SIZE_W-1:0]   out_freed_size
);

  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_valid;
  logic            busy;
  scba_pkg::item_t front_item;
  scba_pkg::item_t back_item;

  scba_front #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_BLOCK   (MAX_BLOCK)
  ) u_front (
    .push           (push),
    .full           (full),
    .in_cmd         (in_cmd),
    .in_block_size  (in_block_size),
    .in_block_start (in_block_start),
    .q_full         (q_full),
    .busy           (busy),
    .q_push         (q_push),
    .q_item         (front_item)
  );

  scba_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .flush    (cfg_we),
    .push     (q_push),
    .item_in  (front_item),
    .full     (q_full),
    .pop      (q_pop),
    .item_out (back_item),
    .valid    (q_valid)
  );

  scba_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_BLOCK   (MAX_BLOCK)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .q_valid            (q_valid),
    .q_item             (back_item),
    .q_pop              (q_pop),
    .busy               (busy),
    .empty              (empty),
    .pop                (pop),
    .out_start_index    (out_start_index),
    .out_status         (out_status),
    .out_from_free_list (out_from_free_list),
    .out_freed_size     (out_freed_size)
  );

endmodule

FILE: sim/scba_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scba_result_checker
// watches the request, result and config ports of the allocator, keeps its
// own copy of the free lists, block marks and bump pointer, and compares each
// result word field by field with the oldest predicted one
// ----------------------------------------------------------------------------
module scba_result_checker #(
  parameter int TABLE_DEPTH = 1024,
  parameter int MAX_BLOCK   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [scba_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          push,
  input  logic                          full,
  input  logic                          in_cmd,
  input  logic [scba_pkg::SIZE_W-1:0]   in_block_size,
  input  logic [scba_pkg::START_W-1:0]  in_block_start,
  input  logic                          empty,
  input  logic                          pop,
  input  logic [scba_pkg::START_W-1:0]  out_start_index,
  input  logic [scba_pkg::STATUS_W-1:0] out_status,
  input  logic                          out_from_free_list,
  input  logic [scba_pkg::SIZE_W-1:0]   out_freed_size,
  output int                            mismatch_count,
  output int                            words_pending
);

  typedef struct {
    logic [scba_pkg::START_W-1:0] start;
    scba_pkg::status_t            status;
    logic                         reused;
    logic [scba_pkg::SIZE_W-1:0]  freed;
  } grant_t;

  // per-size lifo heads, links, block sizes and allocated marks
  bit          head_vld[MAX_BLOCK];
  int unsigned head_idx[MAX_BLOCK];
  bit          chain_vld[TABLE_DEPTH];
  int unsigned chain_idx[TABLE_DEPTH];
  int unsigned block_len[TABLE_DEPTH];
  bit          busy[TABLE_DEPTH];
  int unsigned bump_ptr;
  int unsigned seed_ptr;
  int unsigned seed_cap;

  grant_t grant_q[$];
  grant_t want;
  int     errs = 0;

  assign mismatch_count = errs;
  assign words_pending  = grant_q.size();

  function automatic void restart(input logic [scba_pkg::CFG_W-1:0] boot);
    for (int i = 0; i < MAX_BLOCK; i++) begin
      head_vld[i] = 1'b0;
      head_idx[i] = 0;
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      chain_vld[i] = 1'b0;
      chain_idx[i] = 0;
      block_len[i] = 0;
      busy[i]      = 1'b0;
    end
    seed_cap = (boot > TABLE_DEPTH) ? TABLE_DEPTH : boot;
    bump_ptr = seed_cap;
    seed_ptr = 0;
  endfunction

  function automatic grant_t predict_grant(input logic cmd,
                                           input logic [scba_pkg::SIZE_W-1:0] sz,
                                           input logic [scba_pkg::START_W-1:0] at);
    grant_t      g;
    int unsigned idx;
    int unsigned len;
    g.start  = '0;
    g.status = scba_pkg::ST_OK;
    g.reused = 1'b0;
    g.freed  = '0;
    if (cmd == scba_pkg::CMD_ALLOC) begin
      if (sz == 0 || sz > MAX_BLOCK) begin
        g.status = scba_pkg::ST_NO_SPACE;
      end else if (head_vld[sz-1]) begin
        idx = head_idx[sz-1];
        head_vld[sz-1] = chain_vld[idx];
        head_idx[sz-1] = chain_idx[idx];
        busy[idx]      = 1'b1;
        block_len[idx] = sz;
        g.start  = scba_pkg::START_W'(idx);
        g.reused = 1'b1;
      end else if (sz == 1 && seed_ptr < seed_cap) begin
        // seeds come out in ascending order once the size-one list is empty
        idx = seed_ptr;
        seed_ptr++;
        busy[idx]      = 1'b1;
        block_len[idx] = 1;
        g.start  = scba_pkg::START_W'(idx);
        g.reused = 1'b1;
      end else if (bump_ptr <= TABLE_DEPTH && sz <= TABLE_DEPTH - bump_ptr) begin
        idx = bump_ptr;
        bump_ptr += sz;
        busy[idx]      = 1'b1;
        block_len[idx] = sz;
        g.start = scba_pkg::START_W'(idx);
      end else begin
        g.status = scba_pkg::ST_NO_SPACE;
      end
    end else begin
      g.start = at;
      if (at == 0 || at >= TABLE_DEPTH || !busy[at] || block_len[at] == 0 ||
          block_len[at] > MAX_BLOCK) begin
        g.status = scba_pkg::ST_BAD_FREE;
      end else begin
        len = block_len[at];
        chain_vld[at]   = head_vld[len-1];
        chain_idx[at]   = head_idx[len-1];
        head_vld[len-1] = 1'b1;
        head_idx[len-1] = at;
        busy[at]        = 1'b0;
        g.freed = scba_pkg::SIZE_W'(len);
      end
    end
    return g;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      restart(scba_pkg::BOOT_RESET);
      grant_q.delete();
    end else begin
      // a result word can never belong to a request taken at the same edge
      if (pop && !empty) begin
        if (grant_q.size() == 0) begin
          $error("result word with no request waiting: start_index %0d", out_start_index);
          errs++;
        end else begin
          want = grant_q.pop_front();
          if (out_start_index !== want.start) begin
            $error("start_index: expected %0d, actual %0d", want.start, out_start_index);
            errs++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            errs++;
          end
          if (out_from_free_list !== want.reused) begin
            $error("from_free_list: expected %0d, actual %0d", want.reused,
                   out_from_free_list);
            errs++;
          end
          if (out_freed_size !== want.freed) begin
            $error("freed_size: expected %0d, actual %0d", want.freed, out_freed_size);
            errs++;
          end
        end
      end
      if (cfg_we) begin
        restart(cfg_wdata);
      end
      if (push && !full) begin
        grant_q.push_back(predict_grant(in_cmd, in_block_size, in_block_start));
      end
    end
  end

endmodule

FILE: sim/tb_size_class_block_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_size_class_block_allocator_unit
// drives directed and random allocate / free words and boot_count writes into
// the allocator with random gaps and result stalls; the checker module beside
// the block predicts and compares, this top gives the verdict
// ----------------------------------------------------------------------------
module tb_size_class_block_allocator_unit;

  localparam int TABLE_DEPTH  = 1024;
  localparam int MAX_BLOCK    = 16;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_WORDS = 500;
  localparam int PHASE_WORDS  = RANDOM_WORDS / 4;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          cfg_we    = 1'b0;
  logic [scba_pkg::CFG_W-1:0]    cfg_wdata = '0;
  logic                          push      = 1'b0;
  logic                          full;
  logic                          in_cmd         = scba_pkg::CMD_ALLOC;
  logic [scba_pkg::SIZE_W-1:0]   in_block_size  = '0;
  logic [scba_pkg::START_W-1:0]  in_block_start = '0;
  logic                          empty;
  logic                          pop = 1'b0;
  logic [scba_pkg::START_W-1:0]  out_start_index;
  logic [scba_pkg::STATUS_W-1:0] out_status;
  logic                          out_from_free_list;
  logic [scba_pkg::SIZE_W-1:0]   out_freed_size;

  int   mismatch_count;
  int   words_pending;
  int   cycles   = 0;
  logic in_taken = 1'b0;
  bit   quiet    = 1'b0;

  // blocks known to be allocated, and recently freed ones for double frees
  logic [scba_pkg::START_W-1:0] live_q[$];
  logic [scba_pkg::START_W-1:0] dead_q[$];

  always #5 clk = ~clk;

  size_class_block_allocator_unit #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .MAX_BLOCK  (MAX_BLOCK)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .push              (push),
    .full              (full),
    .in_cmd            (in_cmd),
    .in_block_size     (in_block_size),
    .in_block_start    (in_block_start),
    .empty             (empty),
    .pop               (pop),
    .out_start_index   (out_start_index),
    .out_status        (out_status),
    .out_from_free_list(out_from_free_list),
    .out_freed_size    (out_freed_size)
  );

  scba_result_checker #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .MAX_BLOCK  (MAX_BLOCK)
  ) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .push              (push),
    .full              (full),
    .in_cmd            (in_cmd),
    .in_block_size     (in_block_size),
    .in_block_start    (in_block_start),
    .empty             (empty),
    .pop               (pop),
    .out_start_index   (out_start_index),
    .out_status        (out_status),
    .out_from_free_list(out_from_free_list),
    .out_freed_size    (out_freed_size),
    .mismatch_count    (mismatch_count),
    .words_pending     (words_pending)
  );

  always @(posedge clk) begin
    in_taken <= push && !full;
    // a successful allocate word carries no freed size
    if (pop && !empty && out_status == scba_pkg::ST_OK && out_freed_size == 0) begin
      live_q.push_back(out_start_index);
    end
  end

  always @(negedge clk) begin
    pop <= quiet || ($urandom_range(0, 99) >= 35);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // entered at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input logic cmd, input logic [scba_pkg::SIZE_W-1:0] sz,
                           input logic [scba_pkg::START_W-1:0] at);
    while (!quiet && $urandom_range(0, 99) < 35) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push           <= 1'b1;
    in_cmd         <= cmd;
    in_block_size  <= sz;
    in_block_start <= at;
    do @(negedge clk); while (!in_taken);
  endtask

  task automatic set_boot(input logic [scba_pkg::CFG_W-1:0] boot);
    push <= 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= boot;
    @(negedge clk);
    cfg_we <= 1'b0;
    live_q.delete();
    dead_q.delete();
  endtask

  initial begin
    int unsigned                  roll;
    int                           pick;
    int                           n;
    logic [scba_pkg::START_W-1:0] at;
    logic [scba_pkg::SIZE_W-1:0]  sz;
    logic [scba_pkg::CFG_W-1:0]   boots[4];

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // boot_count at its reset value of one
    send_word(scba_pkg::CMD_ALLOC, 5'd1, scba_pkg::START_W'($urandom));   // only seed
    send_word(scba_pkg::CMD_ALLOC, 5'd1, scba_pkg::START_W'($urandom));   // bump at 1
    // largest block, bump at 2
    send_word(scba_pkg::CMD_ALLOC, 5'd16, scba_pkg::START_W'($urandom));
    send_word(scba_pkg::CMD_ALLOC, 5'd0, scba_pkg::START_W'($urandom));   // zero size
    // just above largest size
    send_word(scba_pkg::CMD_ALLOC, 5'd17, scba_pkg::START_W'($urandom));
    // index zero is never freeable
    send_word(scba_pkg::CMD_FREE, scba_pkg::SIZE_W'($urandom), 10'd0);
    send_word(scba_pkg::CMD_FREE, scba_pkg::SIZE_W'($urandom), 10'd1023); // never allocated
    send_word(scba_pkg::CMD_FREE, scba_pkg::SIZE_W'($urandom), 10'd1);
    send_word(scba_pkg::CMD_FREE, scba_pkg::SIZE_W'($urandom), 10'd1);    // double free
    send_word(scba_pkg::CMD_FREE, scba_pkg::SIZE_W'($urandom), 10'd2);
    // reuse from size-16 list
    send_word(scba_pkg::CMD_ALLOC, 5'd16, scba_pkg::START_W'($urandom));
    send_word(scba_pkg::CMD_ALLOC, 5'd3, scba_pkg::START_W'($urandom));
    send_word(scba_pkg::CMD_ALLOC, 5'd3, scba_pkg::START_W'($urandom));
    send_word(scba_pkg::CMD_FREE, scba_pkg::SIZE_W'($urandom), 10'd18);
    send_word(scba_pkg::CMD_FREE, scba_pkg::SIZE_W'($urandom), 10'd21);
    // last freed comes back first
    send_word(scba_pkg::CMD_ALLOC, 5'd3, scba_pkg::START_W'($urandom));

    set_boot(11'd4);
    // seed not yet handed out
    send_word(scba_pkg::CMD_FREE, scba_pkg::SIZE_W'($urandom), 10'd3);
    send_word(scba_pkg::CMD_ALLOC, 5'd1, scba_pkg::START_W'($urandom));
    send_word(scba_pkg::CMD_ALLOC, 5'd1, scba_pkg::START_W'($urandom));
    send_word(scba_pkg::CMD_FREE, scba_pkg::SIZE_W'($urandom), 10'd1);
    // list wins over seeds
    send_word(scba_pkg::CMD_ALLOC, 5'd1, scba_pkg::START_W'($urandom));

    set_boot(11'd2047);                                // clamps to table depth
    send_word(scba_pkg::CMD_ALLOC, 5'd2, scba_pkg::START_W'($urandom));
    send_word(scba_pkg::CMD_ALLOC, 5'd1, scba_pkg::START_W'($urandom));

    set_boot(11'd1020);
    // fills the table exactly
    send_word(scba_pkg::CMD_ALLOC, 5'd4, scba_pkg::START_W'($urandom));
    send_word(scba_pkg::CMD_ALLOC, 5'd4, scba_pkg::START_W'($urandom));

    set_boot(11'd0);
    // no seeds, bump at 0
    send_word(scba_pkg::CMD_ALLOC, 5'd1, scba_pkg::START_W'($urandom));
    send_word(scba_pkg::CMD_FREE, scba_pkg::SIZE_W'($urandom), 10'd0);

    boots[0] = 11'd1;
    boots[1] = scba_pkg::CFG_W'($urandom_range(2, 64));
    boots[2] = scba_pkg::CFG_W'($urandom_range(1025, 2047));
    boots[3] = scba_pkg::CFG_W'($urandom_range(0, 1023));
    n = 0;
    for (int p = 0; p < 4; p++) begin
      set_boot(boots[p]);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        quiet = (n >= 200 && n < 300);
        roll  = $urandom_range(0, 99);
        if (roll < 6) begin
          // noise: any field value at all
          send_word(1'($urandom), scba_pkg::SIZE_W'($urandom),
                    scba_pkg::START_W'($urandom));
        end else if (roll < 46 && live_q.size() != 0) begin
          pick = $urandom_range(0, live_q.size() - 1);
          at   = live_q[pick];
          live_q.delete(pick);
          dead_q.push_back(at);
          if (dead_q.size() > 32) dead_q.delete(0);
          send_word(scba_pkg::CMD_FREE, scba_pkg::SIZE_W'($urandom), at);
        end else if (roll < 50 && dead_q.size() != 0) begin
          at = dead_q[$urandom_range(0, dead_q.size() - 1)];
          send_word(scba_pkg::CMD_FREE, scba_pkg::SIZE_W'($urandom), at);
        end else begin
          sz = $urandom_range(0, 1) ? scba_pkg::SIZE_W'($urandom_range(1, 4))
                                    : scba_pkg::SIZE_W'($urandom_range(1, MAX_BLOCK));
          send_word(scba_pkg::CMD_ALLOC, sz, scba_pkg::START_W'($urandom));
        end
        n++;
      end
    end
    quiet = 1'b0;
    push <= 1'b0;

    for (int w = 0; w < 20000 && words_pending != 0; w++) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
